@@ src/fre_pkg.sv @@
// shared types, constants and the byte classifier for the fasta base encoder
`default_nettype none
package fre_pkg;

  localparam int MAX_SEQ_LEN_DEF = 1048576;
  localparam int SEQ_LEN_W       = 21;
  localparam int POS_W           = 20;
  localparam int CODE_W          = 3;
  localparam int BYTE_W          = 8;
  localparam int TDATA_OUT_W     = 24;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;
  localparam int QUEUE_DEPTH     = 4;

  // register index, taken from paddr[2]
  localparam logic REG_SEQ_LEN = 1'b0;

  localparam logic [CODE_W-1:0] CODE_SHORT = 3'd0;
  localparam logic [CODE_W-1:0] CODE_T     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_C     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_G     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_A     = 3'd4;
  localparam logic [CODE_W-1:0] CODE_N     = 3'd5;
  localparam logic [CODE_W-1:0] CODE_GAP   = 3'd6;

  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_C_UP  = 8'h43;
  localparam logic [BYTE_W-1:0] CH_C_LO  = 8'h63;
  localparam logic [BYTE_W-1:0] CH_G_UP  = 8'h47;
  localparam logic [BYTE_W-1:0] CH_G_LO  = 8'h67;
  localparam logic [BYTE_W-1:0] CH_T_UP  = 8'h54;
  localparam logic [BYTE_W-1:0] CH_T_LO  = 8'h74;
  localparam logic [BYTE_W-1:0] CH_U_UP  = 8'h55;
  localparam logic [BYTE_W-1:0] CH_U_LO  = 8'h75;
  localparam logic [BYTE_W-1:0] CH_N_UP  = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_N_LO  = 8'h6E;

  // one classified input byte as it sits in the queue
  typedef struct packed {
    logic              eof;
    logic              is_gt;
    logic              is_eol;
    logic [CODE_W-1:0] code;
  } fre_class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fre_qstat_t;

  function automatic logic [CODE_W-1:0] encode_byte(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] c;
    case (b) inside
      CH_A_UP, CH_A_LO:                   c = CODE_A;
      CH_C_UP, CH_C_LO:                   c = CODE_C;
      CH_G_UP, CH_G_LO:                   c = CODE_G;
      CH_T_UP, CH_T_LO, CH_U_UP, CH_U_LO: c = CODE_T;
      CH_N_UP, CH_N_LO, CH_QUEST:         c = CODE_N;
      CH_DASH:                            c = CODE_GAP;
      default:                            c = CODE_SHORT;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/fre_front.sv @@
// input side: takes stream bytes and classifies them for the queue
`default_nettype none
module fre_front (
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [fre_pkg::BYTE_W-1:0]  s_axis_tdata,
  input  wire logic                        s_axis_tlast,
  input  wire fre_pkg::fre_qstat_t         qstat,
  output logic                             push,
  output fre_pkg::fre_class_t              push_item
);

  assign s_axis_tready = !qstat.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    push_item.eof    = s_axis_tlast;
    push_item.is_gt  = (s_axis_tdata == fre_pkg::CH_GT);
    push_item.is_eol = (s_axis_tdata == fre_pkg::CH_LF) || (s_axis_tdata == fre_pkg::CH_CR) ||
                       (s_axis_tdata == fre_pkg::CH_TAB);
    push_item.code   = fre_pkg::encode_byte(s_axis_tdata);
  end

endmodule
`default_nettype wire

@@ src/fre_queue.sv @@
// small fifo of classified bytes between front and back
`default_nettype none
module fre_queue #(
  parameter int DEPTH = fre_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire fre_pkg::fre_class_t push_item,
  input  wire logic                pop,
  output fre_pkg::fre_class_t      pop_item,
  output logic                     pop_valid,
  output fre_pkg::fre_qstat_t      qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fre_pkg::fre_class_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_valid   = !qstat.empty;
  assign pop_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/fre_back.sv @@
// parser state machine and output register
`default_nettype none
module fre_back #(
  parameter int LEN_W = fre_pkg::SEQ_LEN_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [LEN_W-1:0]            eff_len,
  input  wire fre_pkg::fre_class_t         pop_item,
  input  wire logic                        pop_valid,
  output logic                             pop,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [fre_pkg::CODE_W-1:0]       out_code,
  output logic [fre_pkg::POS_W-1:0]        out_pos,
  output logic                             m_axis_tlast
);

  typedef enum logic [2:0] {
    PH_SEEK = 3'b001,
    PH_HEAD = 3'b010,
    PH_SEQ  = 3'b100
  } phase_t;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] count, count_next;
  logic             res_valid;
  logic [fre_pkg::CODE_W-1:0] res_code;
  logic             res_last;
  logic [LEN_W:0]   count_inc;
  logic             hit_len;

  assign pop       = pop_valid && (!m_axis_tvalid || m_axis_tready);
  assign count_inc = (LEN_W+1)'(count) + (LEN_W+1)'(1);
  assign hit_len   = count_inc >= (LEN_W+1)'(eff_len);

  always_comb begin
    phase_next = phase;
    count_next = count;
    res_valid  = 1'b0;
    res_code   = fre_pkg::CODE_SHORT;
    res_last   = 1'b0;
    unique case (phase)
      PH_SEQ: begin
        if (pop_item.eof || pop_item.is_gt) begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          count_next = '0;
          phase_next = pop_item.eof ? PH_SEEK : PH_HEAD;
        end else if (pop_item.code != fre_pkg::CODE_SHORT) begin
          res_valid = 1'b1;
          res_code  = pop_item.code;
          res_last  = hit_len;
          if (hit_len) begin
            count_next = '0;
            phase_next = PH_SEEK;
          end else begin
            count_next = count_inc[LEN_W-1:0];
          end
        end
      end
      PH_HEAD: begin
        if (pop_item.eof) begin
          phase_next = PH_SEEK;
          count_next = '0;
        end else if (pop_item.is_eol) begin
          phase_next = PH_SEQ;
          count_next = '0;
        end
      end
      default: begin
        count_next = '0;
        phase_next = (!pop_item.eof && pop_item.is_gt) ? PH_HEAD : PH_SEEK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEEK;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        count <= count_next;
      end
      if (pop && res_valid) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_code     <= res_code;
      out_pos      <= count[fre_pkg::POS_W-1:0];
      m_axis_tlast <= res_last;
    end
  end

endmodule
`default_nettype wire

@@ src/fasta_record_base_encoder.sv @@
// FASTA record base encoder: byte stream in, one nucleotide code per symbol out
//
// input stream: one text byte per transfer on s_axis_tdata; s_axis_tlast set
// marks end of file (that byte is not parsed). output stream: one result per
// recognized symbol, m_axis_tdata = {pad, position, base_code}, m_axis_tlast
// on the final symbol of a record or on the short-record result (code 0).
// seq_length is set over the apb port at address 0; the user must set it only
// while no stream is moving, as the block itself does not enforce this; zero
// acts as 1 and values above MAX_SEQ_LEN act as MAX_SEQ_LEN. throughput: one
// byte per clock sustained while m_axis_tready does not stall the output. a
// result goes from its byte transfer into the queue, then through the parser
// into the output register. a four-entry queue sits between the classifier and
// the parser, so s_axis_tready drops only after four bytes back up behind a
// stalled m_axis_tready; the output register holds its result until taken.
// reset: parser returns to seeking a '>' header, queue and output clear,
// seq_length returns to 1.
`default_nettype none
module fasta_record_base_encoder #(
  parameter int MAX_SEQ_LEN = fre_pkg::MAX_SEQ_LEN_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [fre_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] symbol_byte
  input  wire logic                             s_axis_tlast,   // end_of_file
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [fre_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,   // [2:0] base_code, [22:3] position
  output logic                                  m_axis_tlast,   // last
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fre_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fre_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fre_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  localparam int CNT_BITS = $clog2(MAX_SEQ_LEN + 1);
  localparam int LEN_W    = (CNT_BITS > fre_pkg::SEQ_LEN_W) ? CNT_BITS : fre_pkg::SEQ_LEN_W;

  logic [fre_pkg::SEQ_LEN_W-1:0] seq_length;
  logic [LEN_W-1:0]              eff_len;
  logic [LEN_W-1:0]              len_ext;
  logic                          cfg_wr;

  fre_pkg::fre_class_t push_item, pop_item;
  fre_pkg::fre_qstat_t qstat;
  logic                push, pop, pop_valid;
  logic [fre_pkg::CODE_W-1:0] out_code;
  logic [fre_pkg::POS_W-1:0]  out_pos;

  // apb register
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[2] == fre_pkg::REG_SEQ_LEN);
  assign prdata  = (paddr[2] == fre_pkg::REG_SEQ_LEN) ?
                   fre_pkg::APB_DATA_W'(seq_length) : '0;
  assign len_ext = LEN_W'(seq_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= fre_pkg::SEQ_LEN_W'(1);
      eff_len    <= LEN_W'(1);
    end else begin
      if (cfg_wr) begin
        seq_length <= pwdata[fre_pkg::SEQ_LEN_W-1:0];
      end
      // clamped length, registered from seq_length after a write
      if (seq_length == '0) begin
        eff_len <= LEN_W'(1);
      end else if (len_ext > LEN_W'(MAX_SEQ_LEN)) begin
        eff_len <= LEN_W'(MAX_SEQ_LEN);
      end else begin
        eff_len <= len_ext;
      end
    end
  end

  fre_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .qstat         (qstat),
    .push          (push),
    .push_item     (push_item)
  );

  fre_queue #(
    .DEPTH (fre_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .qstat     (qstat)
  );

  fre_back #(
    .LEN_W (LEN_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .eff_len       (eff_len),
    .pop_item      (pop_item),
    .pop_valid     (pop_valid),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_code      (out_code),
    .out_pos       (out_pos),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_pos, out_code};

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_code == fre_pkg::CODE_SHORT) |-> m_axis_tlast)
    else $error("short-record result without last");

  a_reset_clears_out: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire
